>>> rtl/i2ctc_pkg.sv
package i2ctc_pkg;

	localparam int RATE_W = 20;
	localparam int CLK_W  = 27;
	localparam int DIV_W  = 28;
	localparam int DEN_W  = 20;

	localparam logic [CLK_W-1:0] CLK_RESET = 27'd8000000;

	localparam int FMP_RATE = 400000;
	localparam int FM_RATE  = 100000;

	localparam int MUL_LOW  = 21;
	localparam int MUL_HIGH = 11;
	localparam int HIGH_RND = 31;
	localparam int NS_SCALE = 68;

	localparam int K_HOLD      = 300;
	localparam int K_FMP_SETUP = 50;
	localparam int K_FM_SETUP  = 100;
	localparam int K_SM_SETUP  = 250;

	localparam int LOW_MAX   = 256;
	localparam int LOW_SH    = $clog2(LOW_MAX);
	localparam int SETUP_MAX = 16;
	localparam int HOLD_MAX  = 15;
	localparam int PRESC_MAX = 16;

	localparam logic [1:0] MODE_SM  = 2'd0;
	localparam logic [1:0] MODE_FM  = 2'd1;
	localparam logic [1:0] MODE_FMP = 2'd2;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [1:0]        mode;
		logic [4:0]        presc;
		logic              err;
	} side_t;

endpackage

>>> rtl/i2ctc_if.sv
interface i2ctc_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] bit_rate;
	modport source (output valid, output bit_rate, input ready);
	modport sink (input valid, input bit_rate, output ready);
endinterface

interface i2ctc_cfg_if;
	logic        valid;
	logic        ready;
	logic [26:0] clock_hz;
	modport source (output valid, output clock_hz, input ready);
	modport sink (input valid, input clock_hz, output ready);
endinterface

interface i2ctc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] timing_word;
	logic [3:0]  prescale_field;
	logic [7:0]  low_count;
	logic [7:0]  high_count;
	logic [3:0]  hold_count;
	logic [3:0]  setup_count;
	logic        range_error;
	modport source (output valid, output timing_word, output prescale_field,
		output low_count, output high_count, output hold_count,
		output setup_count, output range_error, input ready);
	modport sink (input valid, input timing_word, input prescale_field,
		input low_count, input high_count, input hold_count,
		input setup_count, input range_error, output ready);
endinterface

>>> rtl/i2ctc_div_pipe.sv
module i2ctc_div_pipe
	import i2ctc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DIV_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  side_t            in_side,
	output logic             out_valid,
	output logic [DIV_W-1:0] out_quo,
	output side_t            out_side
);

	logic             v_s    [DIV_W];
	logic [DIV_W-1:0] num_s  [DIV_W];
	logic [DEN_W-1:0] rem_s  [DIV_W];
	logic [DEN_W-1:0] den_s  [DIV_W];
	side_t            side_s [DIV_W];

	logic [DIV_W-1:0] num_c [DIV_W];
	logic [DEN_W-1:0] rem_c [DIV_W];

	// one quotient bit per stage, the numerator register shifts the quotient in
	always_comb begin
		logic [DEN_W:0]   t;
		logic [DIV_W-1:0] pn;
		logic [DEN_W-1:0] pr;
		logic [DEN_W-1:0] pd;
		logic             ge;
		for (int i = 0; i < DIV_W; i++) begin
			pn = (i == 0) ? in_num : num_s[(i == 0) ? 0 : i - 1];
			pr = (i == 0) ? '0 : rem_s[(i == 0) ? 0 : i - 1];
			pd = (i == 0) ? in_den : den_s[(i == 0) ? 0 : i - 1];
			t  = {pr, pn[DIV_W-1]};
			ge = (t >= {1'b0, pd});
			rem_c[i] = ge ? DEN_W'(t - {1'b0, pd}) : t[DEN_W-1:0];
			num_c[i] = {pn[DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_W; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 1; i < DIV_W; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DIV_W; i++) begin
				num_s[i] <= num_c[i];
				rem_s[i] <= rem_c[i];
			end
			den_s[0]  <= in_den;
			side_s[0] <= in_side;
			for (int i = 1; i < DIV_W; i++) begin
				den_s[i]  <= den_s[i-1];
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign out_valid = v_s[DIV_W-1];
	assign out_quo   = num_s[DIV_W-1];
	assign out_side  = side_s[DIV_W-1];

endmodule

>>> rtl/i2c_timing_register_calculator_unit.sv
// channel | dir | payload                                    | beat when
// req     | in  | bit_rate                                   | valid && ready
// rsp     | out | timing_word, its five fields, range_error  | valid && ready
// cfg     | in  | clock_hz                                   | valid && ready
// One beat per cycle in, one per cycle out while neither stall below applies; the path
// runs through three 28-stage divider pipelines (clk/rate, clk/prescaler, scaled clk/rate).
// After reset and after each cfg write a sequencer derives the clock period and
// the delay table with one shared radix-2 divider, with req.ready low until it is done.
// The whole pipeline holds while a result waits on rsp; nothing is dropped or repeated.
module i2c_timing_register_calculator_unit
	import i2ctc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	i2ctc_in_if.sink    req,
	i2ctc_out_if.source rsp,
	i2ctc_cfg_if.sink   cfg
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MULT   = 3'd1;
	localparam logic [2:0] ST_PSTART = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;
	localparam logic [2:0] ST_SPER   = 3'd5;
	localparam logic [2:0] ST_KSEL   = 3'd6;

	localparam logic [1:0] JOB_PER = 2'd0;
	localparam logic [1:0] JOB_K   = 2'd1;

	// reciprocal of the hold field limit, scaled by 2^14 and rounded up
	localparam int HOLD_RCP = ((1 << 14) + HOLD_MAX - 1) / HOLD_MAX;

	function automatic logic [8:0] kval(input logic [1:0] k);
		case (k)
			2'd0:    kval = 9'(K_HOLD);
			2'd1:    kval = 9'(K_FMP_SETUP);
			2'd2:    kval = 9'(K_FM_SETUP);
			default: kval = 9'(K_SM_SETUP);
		endcase
	endfunction

	// ---------------- configuration and table sequencer ----------------
	logic [CLK_W-1:0] clock_q;
	logic [2:0]       st_q;
	logic [1:0]       job_q;
	logic [3:0]       pidx_q;
	logic [1:0]       kidx_q;
	logic [4:0]       cnt_q;
	logic [31:0]      dnum_q;
	logic [31:0]      drem_q;
	logic [31:0]      dden_q;
	logic [31:0]      period_q;
	logic [35:0]      sper_q;
	logic [15:0]      tab_q [16];
	logic [8:0]       hold1_q;
	logic [5:0]       set1_q;
	logic [4:0]       fq_o_q;
	logic [4:0]       fc_o_q;

	logic        busy;
	logic [8:0]  kv;
	logic        k_wr;
	logic [8:0]  k_res;
	logic [32:0] dt;
	logic        dge;
	logic [29:0] divm_c;

	assign busy   = (st_q != ST_IDLE);
	assign kv     = kval(kidx_q);
	assign k_wr   = ((st_q == ST_KSEL) && (sper_q >= 36'(kv)))
		|| ((st_q == ST_DONE) && (job_q == JOB_K));
	assign k_res  = (st_q == ST_KSEL) ? 9'd1 : dnum_q[8:0];
	assign dt     = {drem_q, dnum_q[31]};
	assign dge    = (dt >= {1'b0, dden_q});
	assign divm_c = 30'(clock_q[CLK_W-1:4]) * 30'(NS_SCALE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= CLK_RESET;
			st_q    <= ST_MULT;
			job_q   <= JOB_PER;
			pidx_q  <= '0;
			kidx_q  <= '0;
			cnt_q   <= '0;
		end else if (cfg.valid) begin
			clock_q <= cfg.clock_hz;
			st_q    <= ST_MULT;
		end else begin
			case (st_q)
				ST_MULT: begin
					st_q <= ST_PSTART;
				end
				ST_PSTART: begin
					pidx_q <= '0;
					kidx_q <= '0;
					cnt_q  <= '0;
					job_q  <= JOB_PER;
					st_q   <= (dden_q == '0) ? ST_SPER : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) st_q <= ST_DONE;
				end
				ST_DONE: begin
					case (job_q)
						JOB_PER: st_q <= ST_SPER;
						default: ;
					endcase
				end
				ST_SPER: begin
					kidx_q <= '0;
					st_q   <= ST_KSEL;
				end
				ST_KSEL: begin
					if (!k_wr) begin
						job_q <= JOB_K;
						st_q  <= ST_DIV;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			// advance over delays and prescalers after each table entry
			if (k_wr) begin
				if (kidx_q == 2'd3) begin
					kidx_q <= '0;
					if (pidx_q == 4'd15) begin
						st_q <= ST_IDLE;
					end else begin
						pidx_q <= pidx_q + 4'd1;
						st_q   <= ST_SPER;
					end
				end else begin
					kidx_q <= kidx_q + 2'd1;
					st_q   <= ST_KSEL;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_MULT: dden_q <= 32'(divm_c);
			ST_PSTART: begin
				dnum_q <= 32'hFFFF_FFFF;
				drem_q <= '0;
				if (dden_q == '0) period_q <= 32'hFFFF_FFFF;
			end
			ST_DIV: begin
				drem_q <= dge ? 32'(dt - {1'b0, dden_q}) : dt[31:0];
				dnum_q <= {dnum_q[30:0], dge};
			end
			ST_DONE: begin
				drem_q <= '0;
				case (job_q)
					JOB_PER: period_q <= dnum_q;
					default: ;
				endcase
			end
			ST_SPER: sper_q <= 36'(period_q) * 36'({1'b0, pidx_q} + 5'd1);
			ST_KSEL: begin
				dnum_q <= 32'(kv) + sper_q[31:0] - 32'd1;
				dden_q <= sper_q[31:0];
				drem_q <= '0;
			end
			default: ;
		endcase
		if (k_wr) begin
			tab_q[pidx_q][kidx_q*4 +: 4] <= k_res[3:0];
			if (pidx_q == 4'd0 && kidx_q == 2'd0) hold1_q <= k_res;
			if (pidx_q == 4'd0 && kidx_q == 2'd1) set1_q <= k_res[5:0];
		end
		// floor and ceiling of the unscaled hold over its field limit
		fq_o_q <= 5'((24'(hold1_q) * 24'(HOLD_RCP)) >> 14);
		fc_o_q <= 5'(((24'(hold1_q) + 24'(HOLD_MAX - 1)) * 24'(HOLD_RCP)) >> 14);
	end

	// ---------------- item pipeline ----------------
	logic out_valid_q;
	logic adv;
	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv && !busy;

	// s1: clean the rate, pick the mode, form the rounded-up numerator
	logic [RATE_W-1:0] rate_c;
	logic [1:0]        mode_c;
	logic              v_s1;
	logic [RATE_W-1:0] rate_s1;
	logic [1:0]        mode_s1;
	logic [DIV_W-1:0]  numa_s1;

	assign rate_c = (req.bit_rate == '0) ? RATE_W'(1) : req.bit_rate;
	assign mode_c = (rate_c > RATE_W'(FMP_RATE)) ? MODE_FMP
		: ((rate_c > RATE_W'(FM_RATE)) ? MODE_FM : MODE_SM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= req.valid && req.ready;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rate_s1 <= rate_c;
			mode_s1 <= mode_c;
			numa_s1 <= DIV_W'(clock_q) + DIV_W'(rate_c) - DIV_W'(1);
		end
	end

	logic             a_v;
	logic [DIV_W-1:0] a_quo;
	side_t            a_side;
	side_t            s1_side;
	assign s1_side = '{rate: rate_s1, mode: mode_s1, presc: 5'd0, err: 1'b0};

	i2ctc_div_pipe u_div_a (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s1), .in_num(numa_s1), .in_den(rate_s1), .in_side(s1_side),
		.out_valid(a_v), .out_quo(a_quo), .out_side(a_side)
	);

	// s2: SCL low count at prescaler 1
	logic [32:0]      pa21;
	logic             v_s2;
	logic [DIV_W-1:0] low1_s2;
	side_t            side_s2;
	assign pa21 = 33'(a_quo) * 33'(MUL_LOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= a_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= a_side;
			low1_s2 <= (a_side.mode != MODE_SM) ? pa21[32:5] : {1'b0, a_quo[DIV_W-1:1]};
		end
	end

	// s3: prescaler choice, flag and clamp
	logic [DIV_W-LOW_SH-1:0] lq;
	logic [DIV_W-LOW_SH:0]   lc;
	logic [6:0]              s1r;
	logic [4:0]              fq;
	logic [4:0]              fc;
	logic [DIV_W-LOW_SH:0]   raw;
	logic                    v_s3;
	side_t                   side_s3;

	assign lq  = low1_s2[DIV_W-1:LOW_SH];
	assign lc  = {1'b0, lq} + (DIV_W-LOW_SH+1)'(|low1_s2[LOW_SH-1:0]);
	assign s1r = ({1'b0, set1_q} + 7'(SETUP_MAX - 1)) / 7'(SETUP_MAX);
	assign fq  = (side_s2.mode == MODE_FMP) ? 5'(set1_q / 6'(SETUP_MAX)) : fq_o_q;
	assign fc  = (side_s2.mode == MODE_FMP) ? s1r[4:0] : fc_o_q;
	assign raw = (lq > (DIV_W-LOW_SH)'(fq)) ? lc : (DIV_W-LOW_SH+1)'(fc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.rate <= side_s2.rate;
			side_s3.mode <= side_s2.mode;
			side_s3.err  <= (raw == '0) || (raw > (DIV_W-LOW_SH+1)'(PRESC_MAX));
			if (raw == '0) side_s3.presc <= 5'd1;
			else if (raw > (DIV_W-LOW_SH+1)'(PRESC_MAX)) side_s3.presc <= 5'(PRESC_MAX);
			else side_s3.presc <= raw[4:0];
		end
	end

	logic             b_v;
	logic [DIV_W-1:0] b_quo;
	side_t            b_side;

	i2ctc_div_pipe u_div_b (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s3), .in_num(DIV_W'(clock_q)), .in_den(DEN_W'(side_s3.presc)),
		.in_side(side_s3),
		.out_valid(b_v), .out_quo(b_quo), .out_side(b_side)
	);

	// s4: rounded-up numerator for the scaled clock
	logic             v_s4;
	logic [DIV_W-1:0] numc_s4;
	side_t            side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= b_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= b_side;
			numc_s4 <= b_quo + DIV_W'(b_side.rate) - DIV_W'(1);
		end
	end

	logic             c_v;
	logic [DIV_W-1:0] c_quo;
	side_t            c_side;

	i2ctc_div_pipe u_div_c (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(v_s4), .in_num(numc_s4), .in_den(side_s4.rate), .in_side(side_s4),
		.out_valid(c_v), .out_quo(c_quo), .out_side(c_side)
	);

	// s5: final counts, delays from the table, pack
	logic [32:0] pc21;
	logic [32:0] pc11;
	logic [4:0]  pm1;
	logic [15:0] ent;
	logic [7:0]  low8;
	logic [7:0]  high8;
	logic [3:0]  hold4;
	logic [3:0]  setup4;

	assign pc21 = 33'(c_quo) * 33'(MUL_LOW);
	assign pc11 = 33'(c_quo) * 33'(MUL_HIGH) + 33'(HIGH_RND);
	assign pm1  = c_side.presc - 5'd1;
	assign ent  = tab_q[pm1[3:0]];
	assign low8 = (c_side.mode != MODE_SM) ? pc21[12:5] : c_quo[8:1];
	assign high8 = (c_side.mode != MODE_SM) ? pc11[12:5] : low8;
	assign hold4 = (c_side.mode == MODE_FMP) ? 4'd0 : ent[3:0];

	always_comb begin
		case (c_side.mode)
			MODE_FMP: setup4 = ent[7:4];
			MODE_FM:  setup4 = ent[11:8];
			default:  setup4 = ent[15:12];
		endcase
	end

	logic [3:0] pf_q;
	logic [7:0] low_q;
	logic [7:0] high_q;
	logic [3:0] hold_q;
	logic [3:0] setup_q;
	logic       err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= c_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pf_q    <= pm1[3:0];
			low_q   <= low8;
			high_q  <= high8;
			hold_q  <= hold4;
			setup_q <= setup4;
			err_q   <= c_side.err;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.prescale_field = pf_q;
	assign rsp.low_count      = low_q;
	assign rsp.high_count     = high_q;
	assign rsp.hold_count     = hold_q;
	assign rsp.setup_count    = setup_q;
	assign rsp.range_error    = err_q;
	assign rsp.timing_word    = {pf_q, 4'd0, setup_q, hold_q, high_q, low_q};

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !req.ready) else $error("beat accepted while the table is rebuilt");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("beat accepted while the output is stalled");

	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.ready) |=> (st_q == ST_MULT))
		else $error("clock write did not restart the table");

	a_presc_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (side_s4.presc >= 5'd1 && side_s4.presc <= 5'(PRESC_MAX)))
		else $error("prescaler left its clamp range");

endmodule

>>> dv/i2ctc_checker.sv
`timescale 1ns / 1ps

module i2ctc_checker
	import i2ctc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	i2ctc_in_if         req,
	i2ctc_out_if        rsp,
	i2ctc_cfg_if        cfg,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic [31:0] word;
		logic [3:0]  presc;
		logic [7:0]  low;
		logic [7:0]  high;
		logic [3:0]  hold;
		logic [3:0]  setup;
		logic        err;
	} timing_t;

	timing_t          timing_q[$];
	logic [CLK_W-1:0] clk_hz_q;

	function automatic longint unsigned cdiv(longint unsigned a, longint unsigned b);
		if (b == 0)
			return 0;
		return (a + b - 1) / b;
	endfunction

	function automatic longint unsigned scl_low_fast(longint unsigned c, longint unsigned r);
		return (cdiv(c, r) * MUL_LOW) >> 5;
	endfunction

	function automatic longint unsigned scl_high_fast(longint unsigned c, longint unsigned r);
		return (cdiv(c, r) * MUL_HIGH + HIGH_RND) >> 5;
	endfunction

	function automatic timing_t calc_timing(logic [CLK_W-1:0] fclk, logic [RATE_W-1:0] rate_in);
		longint unsigned f, r, dv, per, lo, hi, hd, su, fit, dmax, raw, p, sclk, sper;
		logic [1:0]      mode;
		timing_t         t;
		f = fclk;
		r = (rate_in == 0) ? 1 : rate_in;
		dv = (f >> 4) * NS_SCALE;
		per = (dv == 0) ? 64'hFFFF_FFFF : 64'hFFFF_FFFF / dv;
		if (r > FMP_RATE) begin
			mode = MODE_FMP;
			lo = scl_low_fast(f, r);
			hd = 0;
			su = cdiv(K_FMP_SETUP, per);
			fit = su;
			dmax = SETUP_MAX;
		end else begin
			mode = (r > FM_RATE) ? MODE_FM : MODE_SM;
			lo = (mode == MODE_FM) ? scl_low_fast(f, r) : (cdiv(f, r) >> 1);
			hd = cdiv(K_HOLD, per);
			su = 0;
			fit = hd;
			dmax = HOLD_MAX;
		end
		if (lo / LOW_MAX > fit / dmax)
			raw = cdiv(lo, LOW_MAX);
		else
			raw = cdiv(fit, dmax);
		t.err = (raw < 1) || (raw > PRESC_MAX);
		p = (raw < 1) ? 1 : ((raw > PRESC_MAX) ? PRESC_MAX : raw);
		sclk = f / p;
		sper = per * p;
		case (mode)
			MODE_FMP: begin
				if (p != 1)
					lo = scl_low_fast(sclk, r);
				hi = scl_high_fast(sclk, r);
				su = cdiv(K_FMP_SETUP, sper);
			end
			MODE_FM: begin
				if (p != 1) begin
					lo = scl_low_fast(sclk, r);
					hd = cdiv(K_HOLD, sper);
				end
				hi = scl_high_fast(sclk, r);
				su = cdiv(K_FM_SETUP, sper);
			end
			default: begin
				if (p != 1) begin
					lo = cdiv(sclk, r) >> 1;
					hd = cdiv(K_HOLD, sper);
				end
				hi = lo;
				su = cdiv(K_SM_SETUP, sper);
			end
		endcase
		t.low   = lo[7:0];
		t.high  = hi[7:0];
		t.hold  = hd[3:0];
		t.setup = su[3:0];
		t.presc = 4'(p - 1);
		t.word  = {t.presc, 4'd0, t.setup, t.hold, t.high, t.low};
		return t;
	endfunction

	assign pending = timing_q.size();

	always @(posedge clk or negedge arst_n) begin
		timing_t exp_t;
		if (!arst_n) begin
			clk_hz_q <= CLK_RESET;
			errors = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				clk_hz_q <= cfg.clock_hz;
			if (req.valid && req.ready)
				timing_q.push_back(calc_timing(clk_hz_q, req.bit_rate));
			if (rsp.valid && rsp.ready) begin
				if (timing_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result beat word=%h", rsp.timing_word);
				end else begin
					exp_t = timing_q.pop_front();
					if (rsp.timing_word !== exp_t.word || rsp.prescale_field !== exp_t.presc ||
							rsp.low_count !== exp_t.low || rsp.high_count !== exp_t.high ||
							rsp.hold_count !== exp_t.hold || rsp.setup_count !== exp_t.setup ||
							rsp.range_error !== exp_t.err) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp word=%h p=%h lo=%h hi=%h hd=%h su=%h e=%b, got word=%h p=%h lo=%h hi=%h hd=%h su=%h e=%b",
								exp_t.word, exp_t.presc, exp_t.low, exp_t.high, exp_t.hold,
								exp_t.setup, exp_t.err, rsp.timing_word, rsp.prescale_field,
								rsp.low_count, rsp.high_count, rsp.hold_count,
								rsp.setup_count, rsp.range_error);
					end
				end
			end
		end
	end

endmodule

>>> dv/i2c_timing_register_calculator_unit_tb.sv
`timescale 1ns / 1ps

module i2c_timing_register_calculator_unit_tb;
	import i2ctc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	bit   stall_req = 0;
	bit   no_gaps = 0;

	i2ctc_in_if  req();
	i2ctc_out_if rsp();
	i2ctc_cfg_if cfg();

	always #2 clk = ~clk;

	i2c_timing_register_calculator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	i2ctc_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg     (cfg),
		.errors  (errors),
		.pending (pending)
	);

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [RATE_W-1:0] pick_rate();
		case ($urandom_range(0, 4))
			0: return RATE_W'($urandom_range(0, (1 << RATE_W) - 1));
			1: return RATE_W'($urandom_range(1, FM_RATE));
			2: return RATE_W'($urandom_range(FM_RATE + 1, FMP_RATE));
			3: return RATE_W'($urandom_range(FMP_RATE + 1, 1000000));
			default: return RATE_W'($urandom_range(1, 5000));
		endcase
	endfunction

	task automatic send_rate(logic [RATE_W-1:0] r);
		int g;
		@(negedge clk);
		req.valid <= 1'b1;
		req.bit_rate <= r;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		g = pick_gap();
		if (g > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// drain, allow for the pipeline depth, then write
	task automatic write_clock(logic [CLK_W-1:0] hz);
		@(negedge clk);
		req.valid <= 1'b0;
		wait (pending == 0);
		repeat (120) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.clock_hz <= hz;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// receiver: random ready runs, plus one long hold-off on request
	initial begin
		int run_left;
		int stall_left;
		bit rdy;
		run_left = 0;
		stall_left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req && stall_left == 0)
				stall_left = 400;
			if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0)
					stall_req = 0;
				rsp.ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					rdy = no_gaps || ($urandom_range(0, 2) != 0);
					run_left = rdy ? $urandom_range(1, 20) : pick_gap() + 1;
				end
				run_left--;
				rsp.ready <= rdy;
			end
		end
	end

	initial begin
		logic [CLK_W-1:0] clocks[$];
		logic [RATE_W-1:0] directed[$];
		req.valid = 1'b0;
		req.bit_rate = '0;
		cfg.valid = 1'b0;
		cfg.clock_hz = '0;
		directed = '{0, 1, 2, 3, 100, 1000, 99999, 100000, 100001, 250000, 399999, 400000,
			400001, 500000, 999999, 1000000, 1000001, 20'hFFFFF, 20'h55555, 20'hAAAAA,
			32000, 16, 31};
		clocks = '{1000000, 100000000, 27'h7FFFFFF, 15, 0, 16, 1, 12345678, 48000000};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset clock: directed corner rates, then random rates
		foreach (directed[i])
			send_rate(directed[i]);
		repeat (30)
			send_rate(pick_rate());

		foreach (clocks[k]) begin
			write_clock(clocks[k]);
			no_gaps = (k == 3);
			foreach (directed[i])
				if (i % 4 == k % 4)
					send_rate(directed[i]);
			for (int n = 0; n < 34; n++) begin
				if (k == 1 && n == 5)
					stall_req = 1;
				send_rate(pick_rate());
			end
			no_gaps = 0;
		end

		write_clock(CLK_W'($urandom_range(1000000, 100000000)));
		repeat (40)
			send_rate(pick_rate());

		@(negedge clk);
		req.valid <= 1'b0;
		wait (pending == 0);
		repeat (120) @(posedge clk);
		if (errors == 0)
			$display("PASS i2c_timing_register_calculator_unit");
		else
			$display("FAIL i2c_timing_register_calculator_unit");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAIL i2c_timing_register_calculator_unit");
		$finish;
	end

endmodule
